// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/scf_pkg.sv =====
// Shared constants and types of the smoothed category frequency block
`timescale 1ns / 1ps

package scf_pkg;

    localparam int CFG_W              = 5;
    localparam int CATEGORY_W         = 4;
    localparam int PROB_W             = 32;
    localparam int FRAC_BITS          = 31;
    localparam int RESULT_LIMIT       = 16;
    localparam int MAX_CATEGORIES_DEF = 16;
    localparam int COUNT_BITS_DEF     = 16;

    localparam logic [CFG_W-1:0]  CATEGORY_COUNT_RST = 5'd2;
    localparam logic [PROB_W-1:0] EPSILON_Q31        = 32'd21475;
    localparam logic [PROB_W-1:0] ONE_Q31            = 32'h8000_0000;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } scf_div_stat_t;

endpackage

// ===== design/smoothed_category_frequency_core.sv =====
// A counted sample blocks further input while its count is written back; a dropped one does not.
// End of run: the categories are scanned to count the nonempty ones, then a penalty divide is done
// when needed; then each category gives its result directly (empty) or after one pass of the shared
// divider, each followed by the output beat. The bit-serial divider sets the emit rate.
// Reset (async, active low) clears the histogram valid bits, total and flags at once,
// and sets category_count to 2.
`timescale 1ns / 1ps

module smoothed_category_frequency_core #(
    parameter int MAX_CATEGORIES = scf_pkg::MAX_CATEGORIES_DEF,
    parameter int COUNT_BITS     = scf_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [scf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [scf_pkg::CATEGORY_W-1:0]   category,
    input  logic                             last_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [scf_pkg::CATEGORY_W-1:0]   category_index,
    output logic [scf_pkg::PROB_W-1:0]       probability,
    output logic                             last_result,
    output logic                             bad_label,
    output logic                             count_overflow
);

    import scf_pkg::*;

    localparam int DEPTH = (MAX_CATEGORIES < RESULT_LIMIT) ? MAX_CATEGORIES : RESULT_LIMIT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DVW   = COUNT_BITS + FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]      N_LIM     = CFG_W'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_SCAN,
        S_PEN,
        S_PEN_WAIT,
        S_CAT,
        S_CAT_RD,
        S_CAT_DIV,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      cat_cnt_reg, cat_cnt_next;
    logic [CFG_W-1:0]      n_run_reg, n_run_next;
    logic [AW-1:0]         label_reg, label_next;
    logic                  last_reg, last_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic                  bad_reg, bad_next;
    logic                  ovf_reg, ovf_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CFG_W-1:0]      ne_reg, ne_next;
    logic [PROB_W-1:0]     pen_reg, pen_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PROB_W-1:0]     prob_reg, prob_next;
    logic                  last_res_reg, last_res_next;

    // histogram store; an entry without its valid bit reads as zero
    logic [COUNT_BITS-1:0] hist_mem [DEPTH];
    logic [COUNT_BITS-1:0] rdata_reg;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;

    logic [CFG_W-1:0]      n_use;
    logic                  label_ok;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  cnt_sat;
    logic                  tot_sat;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CFG_W-1:0]      empties;
    logic                  pen_needed;
    logic [PROB_W-1:0]     pen_num;
    logic                  is_last_cat;
    logic [PROB_W-1:0]     q_clip;
    logic [PROB_W-1:0]     q_pen;

    logic                  div_start;
    logic [DVW-1:0]        div_dividend;
    logic [COUNT_BITS-1:0] div_divisor;
    logic [PROB_W-1:0]     div_quo;
    scf_div_stat_t         div_stat;

    assign n_use = (cat_cnt_reg == '0) ? CFG_W'(1) :
                   (cat_cnt_reg > N_LIM) ? N_LIM : cat_cnt_reg;
    assign label_ok = CFG_W'(category) < n_use;

    assign cur_count = valid_reg[label_reg] ? rdata_reg : '0;
    assign cnt_sat   = cur_count == COUNT_MAX;
    assign tot_sat   = total_reg == COUNT_MAX;
    assign cnt_inc   = cnt_sat ? cur_count : cur_count + 1'b1;

    assign empties     = n_run_reg - ne_reg;
    assign pen_needed  = (empties != '0) && (ne_reg != '0);
    assign pen_num     = EPSILON_Q31 * PROB_W'(empties);
    assign is_last_cat = CFG_W'(idx_reg) == (n_run_reg - 1'b1);

    assign q_clip = (div_quo > ONE_Q31) ? ONE_Q31 : div_quo;
    assign q_pen  = (q_clip > pen_reg) ? q_clip - pen_reg : '0;

    assign rd_addr = (state_reg == S_IDLE) ? category[AW-1:0] : idx_reg;
    assign mem_we  = state_reg == S_ACC;

    assign div_start    = !div_stat.busy &&
                          (((state_reg == S_PEN) && pen_needed) || (state_reg == S_CAT_RD));
    assign div_dividend = (state_reg == S_PEN) ? DVW'(pen_num)
                                               : {rdata_reg, {FRAC_BITS{1'b0}}};
    assign div_divisor  = (state_reg == S_PEN) ? COUNT_BITS'(ne_reg) : total_reg;

    scf_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[label_reg] <= cnt_inc;
        end
        rdata_reg <= hist_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        cat_cnt_next   = cat_cnt_reg;
        n_run_next     = n_run_reg;
        label_next     = label_reg;
        last_next      = last_reg;
        valid_next     = valid_reg;
        total_next     = total_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        ne_next        = ne_reg;
        pen_next       = pen_reg;
        out_valid_next = out_valid_reg;
        prob_next      = prob_reg;
        last_res_next  = last_res_reg;

        if (cfg_valid)
        begin
            cat_cnt_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = last_sample;
                    label_next = category[AW-1:0];
                    n_run_next = n_use;
                    if (label_ok)
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        bad_next = 1'b1;
                        if (last_sample)
                        begin
                            idx_next   = '0;
                            ne_next    = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_ACC:
            begin
                valid_next[label_reg] = 1'b1;
                ovf_next = ovf_reg | cnt_sat | tot_sat;
                if (!tot_sat)
                begin
                    total_next = total_reg + 1'b1;
                end
                if (last_reg)
                begin
                    idx_next   = '0;
                    ne_next    = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // a valid entry always holds a count of at least one
                ne_next = ne_reg + CFG_W'(valid_reg[idx_reg]);
                if (is_last_cat)
                begin
                    idx_next   = '0;
                    state_next = S_PEN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PEN:
            begin
                if (!div_stat.busy)
                begin
                    if (pen_needed)
                    begin
                        state_next = S_PEN_WAIT;
                    end
                    else
                    begin
                        pen_next   = '0;
                        state_next = S_CAT;
                    end
                end
            end
            S_PEN_WAIT:
            begin
                if (div_stat.done)
                begin
                    pen_next   = div_quo;
                    state_next = S_CAT;
                end
            end
            S_CAT:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = S_CAT_RD;
                end
                else
                begin
                    prob_next      = EPSILON_Q31;
                    last_res_next  = is_last_cat;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_CAT_RD:
            begin
                if (!div_stat.busy)
                begin
                    state_next = S_CAT_DIV;
                end
            end
            S_CAT_DIV:
            begin
                if (div_stat.done)
                begin
                    prob_next      = q_pen;
                    last_res_next  = is_last_cat;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_res_reg)
                    begin
                        valid_next = '0;
                        total_next = '0;
                        bad_next   = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_CAT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cat_cnt_reg   <= CATEGORY_COUNT_RST;
            n_run_reg     <= CFG_W'(1);
            label_reg     <= '0;
            last_reg      <= 1'b0;
            valid_reg     <= '0;
            total_reg     <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            ne_reg        <= '0;
            pen_reg       <= '0;
            out_valid_reg <= 1'b0;
            prob_reg      <= '0;
            last_res_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cat_cnt_reg   <= cat_cnt_next;
            n_run_reg     <= n_run_next;
            label_reg     <= label_next;
            last_reg      <= last_next;
            valid_reg     <= valid_next;
            total_reg     <= total_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            ne_reg        <= ne_next;
            pen_reg       <= pen_next;
            out_valid_reg <= out_valid_next;
            prob_reg      <= prob_next;
            last_res_reg  <= last_res_next;
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = state_reg == S_IDLE;
    assign out_valid      = out_valid_reg;
    assign category_index = CATEGORY_W'(idx_reg);
    assign probability    = prob_reg;
    assign last_result    = last_res_reg;
    assign bad_label      = bad_reg;
    assign count_overflow = ovf_reg;

endmodule

// ===== design/scf_div.sv =====
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module scf_div #(
    parameter int COUNT_BITS = scf_pkg::COUNT_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [COUNT_BITS+scf_pkg::FRAC_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]                   divisor,
    output logic [scf_pkg::PROB_W-1:0]              quotient,
    output scf_pkg::scf_div_stat_t                  stat
);

    import scf_pkg::*;

    localparam int DVW = COUNT_BITS + FRAC_BITS;
    localparam int CW  = $clog2(DVW + 1);

    logic [DVW-1:0]        dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [PROB_W-1:0]     quo_reg, quo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    // remainder stays below the divisor, so one extra bit covers the shift
    assign trial = {rem_reg, dvd_reg[DVW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(DVW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVW-2:0], 1'b0};
            rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_next = {quo_reg[PROB_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== design/scf_checker.sv =====
// Port-level checker for the smoothed category frequency core, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             last_sample,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [scf_pkg::PROB_W-1:0]       probability,
    input logic                             last_result
);

    // no sample is taken while results of a run are pending
    `SCF_ASSERT_NOW(a_no_input_during_emit, out_valid, !in_ready, "input taken during emit")

    // an unmarked sample never produces a result beat
    `SCF_ASSERT_NEXT(a_unmarked_no_result, in_valid && in_ready && !last_sample, !out_valid,
                     "result after unmarked sample")

    // after the final result of a run the block goes quiet
    `SCF_ASSERT_NEXT(a_final_result_ends, out_valid && out_ready && last_result, !out_valid,
                     "result beat after final result")

    // a stalled result beat holds its value
    `SCF_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                     out_valid && $stable(probability), "stalled result changed")

endmodule

bind smoothed_category_frequency_core scf_checker u_scf_checker (.*);
